// ===== design/ths_pkg.sv =====
// Package for the ternary heap sorter: shared state and mode types.
// No dependencies.
package ths_pkg;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BUILD,
    ST_SD_NODE,
    ST_SD_NVAL,
    ST_SD_C0,
    ST_SD_C1,
    ST_SD_C2,
    ST_SD_CMP,
    ST_SD_END,
    ST_EXT_RD0,
    ST_EXT_RDL,
    ST_EXT_WR,
    ST_OUT_RD,
    ST_OUT_WAIT
  } ths_state_t;

  typedef enum logic [1:0] {
    SD_BUILD,
    SD_SORT
  } ths_mode_t;

endpackage

// ===== design/ths_if.sv =====
// Valid/ready stream interface carrying one payload.
// No dependencies.
interface ths_if #(parameter int W = 34) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/ternary_heap_sorter.sv =====
// Ternary heap sorter: loads up to CAPACITY signed values, one per cycle while in the load
// state, then builds a ternary max-heap in place and heap-sorts it, streaming the values out
// in ascending order. A sift level makes three child reads and a compare; each build parent
// is first fetched and finally settled, and each sort step swaps the root out by reading the
// root and the last value and writing the root to the last slot, then settles. Results leave
// through an output register while out_ready is high, each read from the store first; a
// stalled result holds the back end, and in_ready drops once two requests are queued.
module ternary_heap_sorter #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_WIDTH-1:0] in_value,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] out_sorted_value,
  output logic                  out_last_res,
  output logic                  out_overflow
);
  ths_if #(DATA_WIDTH + 1) a_if (clk);
  ths_if #(DATA_WIDTH + 1) q_if (clk);
  ths_if #(DATA_WIDTH + 2) o_if (clk);

  assign a_if.valid = in_valid;
  assign a_if.data  = {in_value, in_last};
  assign in_ready   = a_if.ready;
  assign out_valid  = o_if.valid;
  assign o_if.ready = out_ready;
  assign out_sorted_value = o_if.data[DATA_WIDTH+1:2];
  assign out_last_res     = o_if.data[1];
  assign out_overflow     = o_if.data[0];

  ths_front #(.W(DATA_WIDTH + 1)) u_front (
    .clk, .rst_n, .in_s(a_if.sink), .q_s(q_if.source)
  );
  ths_back #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk, .rst_n, .q_s(q_if.sink), .out_s(o_if.source)
  );
endmodule

// ===== design/ths_front.sv =====
// Front: two-entry queue between the input and the sort engine.
// Depends on ths_if.
module ths_front #(
  parameter int W = 33
) (
  input  logic     clk,
  input  logic     rst_n,
  ths_if.sink      in_s,
  ths_if.source    q_s
);
  logic [W-1:0] buf_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         push, pop;

  assign in_s.ready = (cnt_r != 2'd2);
  assign push       = in_s.valid && in_s.ready;
  assign pop        = q_s.valid && q_s.ready;
  assign q_s.valid  = (cnt_r != 2'd0);
  assign q_s.data   = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= in_s.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== design/ths_back.sv =====
// Back: heap store memory and sequencer for load, build, sort and output.
// Depends on ths_pkg and ths_if.
module ths_back
  import ths_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic  clk,
  input  logic  rst_n,
  ths_if.sink   q_s,
  ths_if.source out_s
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 3;
  localparam int PW = CW + 9;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_q;

  ths_state_t state_r, state_nxt;
  ths_mode_t  mode_r;
  logic [CW-1:0] count_r, size_r, oidx_r;
  logic          ovf_r;
  logic [AW-1:0] node_r, bidx_r, bld_r;
  logic [DATA_WIDTH-1:0] nval_r, bval_r, tval_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic          out_v_r;
  logic [DATA_WIDTH+1:0] out_d_r;
  logic          last_in;
  logic [DATA_WIDTH-1:0] val_in;
  logic          q_take;
  logic [IW-1:0] c1;
  logic          has_kids, c2in, c3in, move;
  logic [DATA_WIDTH-1:0] mval;
  logic [AW-1:0] midx;
  logic          bld_more, out_free, last_out;
  logic [PW-1:0] par_prod;
  logic [AW-1:0] last_par;

  assign val_in  = q_s.data[DATA_WIDTH:1];
  assign last_in = q_s.data[0];
  assign q_s.ready = (state_r == ST_LOAD);
  assign q_take  = q_s.valid && q_s.ready;
  assign out_s.valid = out_v_r;
  assign out_s.data  = out_d_r;

  function automatic logic less(input logic [DATA_WIDTH-1:0] a, b);
    return $signed(a) < $signed(b);
  endfunction

  // first build node (n+2)/3-1, at or past the last parent, by reciprocal multiply, exact for n below 510
  assign par_prod = (PW'(count_r) + PW'(2)) * PW'(171);
  assign last_par = AW'(par_prod >> 9) - AW'(1);

  assign c1       = IW'(node_r) * IW'(3) + IW'(1);
  assign has_kids = c1 < IW'(size_r);
  assign c2in     = (c1 + IW'(1)) < IW'(size_r);
  assign c3in     = (c1 + IW'(2)) < IW'(size_r);
  assign mval     = (c3in && less(bval_r, rd_q)) ? rd_q : bval_r;
  assign midx     = (c3in && less(bval_r, rd_q)) ? AW'(c1 + IW'(2)) : bidx_r;
  assign move     = less(nval_r, mval);
  assign bld_more = (mode_r == SD_BUILD) && (bld_r != '0);
  assign out_free = !out_v_r || out_s.ready;
  assign last_out = (CW'(oidx_r + CW'(1)) == count_r);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  // memory control
  always_comb begin
    rd_addr = node_r;
    wr_en   = 1'b0;
    wr_addr = node_r;
    wr_data = nval_r;
    unique case (state_r)
      ST_LOAD: begin
        wr_en   = q_take && (count_r < CW'(CAPACITY));
        wr_addr = count_r[AW-1:0];
        wr_data = val_in;
      end
      ST_SD_NODE: rd_addr = node_r;
      ST_SD_NVAL, ST_SD_C0: rd_addr = c1[AW-1:0];
      ST_SD_C1: rd_addr = AW'(c1 + IW'(1));
      ST_SD_C2: rd_addr = AW'(c1 + IW'(2));
      ST_SD_CMP: begin
        wr_en = move; wr_addr = node_r; wr_data = mval;
      end
      ST_SD_END: begin
        wr_en = 1'b1; wr_addr = node_r; wr_data = nval_r;
      end
      ST_EXT_RD0: rd_addr = '0;
      ST_EXT_RDL: rd_addr = AW'(size_r - CW'(1));
      ST_EXT_WR: begin
        wr_en = 1'b1; wr_addr = AW'(size_r - CW'(1)); wr_data = tval_r;
      end
      ST_OUT_RD, ST_OUT_WAIT: rd_addr = oidx_r[AW-1:0];
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:
        if (q_take && last_in) state_nxt = ST_BUILD;
      ST_BUILD: begin
        if (count_r < CW'(2)) state_nxt = ST_OUT_RD;
        else state_nxt = ST_SD_NODE;
      end
      ST_SD_NODE: state_nxt = ST_SD_NVAL;
      ST_SD_NVAL, ST_SD_C0: state_nxt = has_kids ? ST_SD_C1 : ST_SD_END;
      ST_SD_C1: state_nxt = ST_SD_C2;
      ST_SD_C2: state_nxt = ST_SD_CMP;
      ST_SD_CMP: state_nxt = move ? ST_SD_C0 : ST_SD_END;
      ST_SD_END: begin
        if (bld_more) state_nxt = ST_SD_NODE;
        else if (size_r > CW'(1)) state_nxt = ST_EXT_RD0;
        else state_nxt = ST_OUT_RD;
      end
      ST_EXT_RD0: state_nxt = ST_EXT_RDL;
      ST_EXT_RDL: state_nxt = ST_EXT_WR;
      ST_EXT_WR: state_nxt = ST_SD_C0;
      ST_OUT_RD: state_nxt = ST_OUT_WAIT;
      ST_OUT_WAIT:
        if (out_free) state_nxt = last_out ? ST_LOAD : ST_OUT_RD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
      out_v_r <= 1'b0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_LOAD && q_take) begin
        if (count_r < CW'(CAPACITY)) count_r <= count_r + CW'(1);
        else ovf_r <= 1'b1;
      end
      if (state_r == ST_OUT_WAIT && out_free) begin
        out_v_r <= 1'b1;
        oidx_r  <= last_out ? '0 : oidx_r + CW'(1);
        if (last_out) begin
          count_r <= '0; ovf_r <= 1'b0;
        end
      end else if (out_s.valid && out_s.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_BUILD: begin
        mode_r <= SD_BUILD;
        size_r <= count_r;
        bld_r  <= last_par;
        node_r <= last_par;
      end
      ST_SD_NVAL: nval_r <= rd_q;
      ST_SD_C1: begin
        bval_r <= rd_q; bidx_r <= AW'(c1);
      end
      ST_SD_C2: if (c2in && less(bval_r, rd_q)) begin
        bval_r <= rd_q; bidx_r <= AW'(c1 + IW'(1));
      end
      ST_SD_CMP: if (move) node_r <= midx;
      ST_SD_END: begin
        if (bld_more) begin
          bld_r <= bld_r - AW'(1); node_r <= bld_r - AW'(1);
        end else begin
          mode_r <= SD_SORT;
        end
      end
      ST_EXT_RDL: tval_r <= rd_q;
      ST_EXT_WR: begin
        nval_r <= rd_q;
        size_r <= size_r - CW'(1);
        node_r <= '0;
      end
      ST_OUT_WAIT: if (out_free) out_d_r <= {rd_q, last_out, ovf_r};
      default: ;
    endcase
  end
endmodule

// ===== design/ths_checker.sv =====
// Port checker for the ternary heap sorter, bound to the top level.
// Depends on ternary_heap_sorter ports only.
module ths_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_last_res,
  input logic out_overflow
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("out_valid dropped");
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_res ##1 out_valid |->
    out_overflow == $past(out_overflow) || !$past(out_valid))
    else $error("overflow changed in set");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule

bind ternary_heap_sorter ths_checker u_chk (.*);

// ===== tb/sv/testbench.sv =====
// Testbench for ternary_heap_sorter: drives data sets of signed values, predicts the
// ascending result stream with overflow and last flags, and checks every result.
// Depends on ths_pkg, ths_if and the ternary_heap_sorter RTL.
module testbench;
  import ths_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW  = 32;
  localparam int CAP = 64;

  typedef struct {
    logic signed [DW-1:0] value;
    logic                 last;
    logic                 wait_drain;
  } request_t;

  typedef struct {
    logic signed [DW-1:0] sorted_value;
    logic                 last_res;
    logic                 overflow;
  } sorted_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ths_if #(.W(DW + 1)) in_ch (clk);
  ths_if #(.W(DW + 2)) out_ch (clk);

  ternary_heap_sorter #(.CAPACITY(CAP), .DATA_WIDTH(DW)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .in_value(in_ch.data[DW-1:0]),
    .in_last(in_ch.data[DW]),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_sorted_value(out_ch.data[DW-1:0]),
    .out_last_res(out_ch.data[DW]),
    .out_overflow(out_ch.data[DW+1])
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  request_t             pending_q[$];
  sorted_t              expected_q[$];
  logic signed [DW-1:0] set_vals[$];
  logic                 set_dropped = 1'b0;
  int                   errors = 0;
  int                   acc_cnt = 0;
  int                   sent_cnt = 0;
  bit                   quiet = 1'b0;
  bit                   rx_hold = 1'b0;
  int                   tx_idle = 0;
  int                   rx_idle = 0;

  function automatic logic signed [DW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: pick_value = 32'sh7fffffff;
      1: pick_value = 32'sh80000000;
      2: pick_value = 0;
      3: pick_value = -1;
      4: pick_value = $signed(32'($urandom_range(0, 7)) - 32'd4);
      default: pick_value = $signed($urandom());
    endcase
  endfunction

  task automatic push_set(input int n, input bit drain_first);
    request_t r;
    for (int i = 0; i < n; i++) begin
      r.value = pick_value();
      r.last = (i == n - 1);
      r.wait_drain = drain_first && (i == 0);
      pending_q.insert(pending_q.size(), r);
    end
  endtask

  task automatic push_fixed(input logic signed [DW-1:0] v, input logic l);
    request_t r;
    r.value = v;
    r.last = l;
    r.wait_drain = 1'b0;
    pending_q.insert(pending_q.size(), r);
  endtask

  // Store the value (or drop it once full); on last, emit the ascending set.
  task automatic predict_sorted(input logic signed [DW-1:0] v, input logic l);
    logic signed [DW-1:0] t;
    sorted_t s;
    int j;
    if (set_vals.size() < CAP) set_vals.insert(set_vals.size(), v);
    else set_dropped = 1'b1;
    if (l) begin
      for (int i = 1; i < set_vals.size(); i++) begin
        t = set_vals[i];
        j = i - 1;
        while (j >= 0 && set_vals[j] > t) begin
          set_vals[j+1] = set_vals[j];
          j--;
        end
        set_vals[j+1] = t;
      end
      for (int i = 0; i < set_vals.size(); i++) begin
        s.sorted_value = set_vals[i];
        s.last_res = (i == set_vals.size() - 1);
        s.overflow = set_dropped;
        expected_q.insert(expected_q.size(), s);
      end
      set_vals.delete();
      set_dropped = 1'b0;
    end
  endtask

  // Acceptance and result checking on the rising edge.
  always @(posedge clk) begin
    sorted_t e;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_sorted($signed(in_ch.data[DW-1:0]), in_ch.data[DW]);
      acc_cnt <= acc_cnt + 1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result sorted_value=%0d", $signed(out_ch.data[DW-1:0]));
        errors++;
      end else begin
        e = expected_q.pop_front();
        if ($signed(out_ch.data[DW-1:0]) !== e.sorted_value) begin
          $error("sorted_value expected %0d actual %0d", e.sorted_value,
                 $signed(out_ch.data[DW-1:0]));
          errors++;
        end
        if (out_ch.data[DW] !== e.last_res) begin
          $error("last_res expected %0b actual %0b", e.last_res, out_ch.data[DW]);
          errors++;
        end
        if (out_ch.data[DW+1] !== e.overflow) begin
          $error("overflow expected %0b actual %0b", e.overflow, out_ch.data[DW+1]);
          errors++;
        end
      end
    end
  end

  // Request driver.
  always @(negedge clk) begin
    request_t r;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else if (!(in_ch.valid && acc_cnt != sent_cnt)) begin
      if (tx_idle > 0) begin
        in_ch.valid <= 1'b0;
        tx_idle <= tx_idle - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        in_ch.valid <= 1'b0;
        tx_idle <= $urandom_range(1, 13);
      end else if (pending_q.size() > 0 &&
                   !(pending_q[0].wait_drain && expected_q.size() > 0)) begin
        r = pending_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.data <= {r.last, r.value};
        sent_cnt <= sent_cnt + 1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink.
  always @(negedge clk) begin
    if (!rst_n || rx_hold) begin
      out_ch.ready <= 1'b0;
    end else if (rx_idle > 0) begin
      out_ch.ready <= 1'b0;
      rx_idle <= rx_idle - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      rx_idle <= $urandom_range(1, 13);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Long receiver hold-off while requests keep coming.
  initial begin
    repeat (400) @(posedge clk);
    @(negedge clk);
    rx_hold <= 1'b1;
    repeat (600) @(negedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #2000000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    int n_items;
    push_fixed(32'sh7fffffff, 1'b1);
    push_fixed(32'sh80000000, 1'b1);
    push_fixed(32'sh80000000, 1'b0);
    push_fixed(32'sh7fffffff, 1'b0);
    push_fixed(0, 1'b0);
    push_fixed(-1, 1'b0);
    push_fixed(1, 1'b0);
    push_fixed(32'sh80000000, 1'b1);
    push_fixed(5, 1'b0);
    push_fixed(5, 1'b0);
    push_fixed(-5, 1'b0);
    push_fixed(5, 1'b1);
    push_fixed(32'shaaaaaaaa, 1'b0);
    push_fixed(32'sh55555555, 1'b0);
    push_fixed(32'sh00000001, 1'b0);
    push_fixed(32'shfffffffe, 1'b1);
    push_set(5, 1'b0);
    push_set(3, 1'b0);
    push_set(CAP, 1'b0);
    push_set(6, 1'b1);
    push_set(CAP + 3, 1'b0);
    push_set(4, 1'b1);
    while (pending_q.size() < 170) push_set($urandom_range(1, 9), $urandom_range(0, 7) == 0);
    n_items = pending_q.size();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    wait (pending_q.size() < 25);
    quiet = 1'b1;
    wait (acc_cnt == n_items);
    wait (expected_q.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end
endmodule

// ===== sim.f =====
design/ths_pkg.sv
design/ths_if.sv
design/ths_front.sv
design/ths_back.sv
design/ternary_heap_sorter.sv
design/ths_checker.sv
tb/sv/testbench.sv
